// File: design/oscillator_divider_register_solver_defines.svh
// Assertion macros used by the oscillator register solver checker.
`ifndef OSCILLATOR_DIVIDER_REGISTER_SOLVER_DEFINES_SVH
`define OSCILLATOR_DIVIDER_REGISTER_SOLVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ODRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ODRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/odrs_pkg.sv
// Constants, tables and types for the oscillator register solver.
`timescale 1ns / 1ps

package odrs_pkg;

  localparam int TARGET_W = 30;
  localparam int XTAL_W   = 27;
  localparam int DCO_W    = 41;   // 11-bit N1*HS times 30-bit target
  localparam int BEST_W   = 33;   // any in-range oscillator frequency
  localparam int RFREQ_W  = 38;
  localparam int NUM_W    = 62;   // 2 * dco * 2^28 plus crystal
  localparam int NH_W     = 11;

  localparam logic [DCO_W-1:0] DCO_MIN_HZ = 41'd4850000000;
  localparam logic [DCO_W-1:0] DCO_MAX_HZ = 41'd5670000000;
  localparam logic [XTAL_W-1:0] XTAL_RESET_HZ = 27'd114285000;

  localparam logic [6:0] K_LAST = 7'd64;   // N1 = 128
  localparam logic [2:0] H_LAST = 3'd5;    // HS = 4
  localparam logic [5:0] DIV_STEPS = 6'd62;

  localparam int WORD_COUNT = 9;
  localparam logic [3:0] WORD_LAST = 4'(WORD_COUNT - 1);

  // Register map of the oscillator chip
  localparam logic [7:0] REG_HS_N1   = 8'h07;
  localparam logic [7:0] REG_N1_RF   = 8'h08;
  localparam logic [7:0] REG_RF_3    = 8'h09;
  localparam logic [7:0] REG_RF_2    = 8'h0A;
  localparam logic [7:0] REG_RF_1    = 8'h0B;
  localparam logic [7:0] REG_RF_0    = 8'h0C;
  localparam logic [7:0] REG_NEWFREQ = 8'h87;
  localparam logic [7:0] REG_FREEZE  = 8'h89;
  localparam logic [7:0] DATA_FREEZE  = 8'h10;
  localparam logic [7:0] DATA_THAW    = 8'h00;
  localparam logic [7:0] DATA_NEWFREQ = 8'h40;

  // APB register index of the crystal frequency
  localparam logic CFG_XTAL = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  // High-speed divider in search order
  function automatic logic [3:0] hs_of(input logic [2:0] h);
    logic [3:0] v;
    unique case (h)
      3'd0:    v = 4'd11;
      3'd1:    v = 4'd9;
      3'd2:    v = 4'd7;
      3'd3:    v = 4'd6;
      3'd4:    v = 4'd5;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] word_addr(input logic [3:0] w);
    logic [7:0] a;
    unique case (w)
      4'd1:    a = REG_HS_N1;
      4'd2:    a = REG_N1_RF;
      4'd3:    a = REG_RF_3;
      4'd4:    a = REG_RF_2;
      4'd5:    a = REG_RF_1;
      4'd6:    a = REG_RF_0;
      4'd8:    a = REG_NEWFREQ;
      default: a = REG_FREEZE;
    endcase
    return a;
  endfunction

endpackage

// File: design/oscillator_divider_register_solver.sv
// Top level of the oscillator divider and RFREQ register solver.
`timescale 1ns / 1ps
//
// Usage: send a target output frequency in hertz as one request on the
// s_t* channel (tdata[29:0]). The block answers with nine register writes
// on the m_t* channel: tdata[7:0] address, tdata[15:8] data, tlast on the
// ninth write, tuser set on all nine when no divider pair fits.
// The crystal frequency register sits at APB address 0 (reset 114285000).
// Sequence: divider search (390 N1/HS pairs issued one per cycle into a
// three-stage multiply and compare pipe, then its drain), then bit-serial
// restoring division for RFREQ (skipped when nothing fits), then one write
// per cycle while the receiver is ready. No new request is taken before
// the previous one is finished: s_tready is low from acceptance until the
// last write is taken. A stalled receiver holds the current write steady.
// Reset clears the sequencer and restores the crystal register default.
//
module oscillator_divider_register_solver (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [29:0] target_frequency_hz
  // register write channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] register_address, [15:8] register_data
  output logic        m_tlast,   // last_word
  output logic        m_tuser,   // no_solution
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  odrs_pkg::state_t state, state_next;

  logic [odrs_pkg::XTAL_W-1:0]   xtal;
  logic [odrs_pkg::TARGET_W-1:0] target;

  // search issue counters
  logic [6:0] k;
  logic [2:0] h;
  logic       issue_done;
  logic [7:0] n1_cur;
  logic [3:0] hs_cur;

  // pipe stage A: N1*HS
  logic                        a_valid;
  logic [odrs_pkg::NH_W-1:0]   a_nh;
  logic [7:0]                  a_n1;
  logic [3:0]                  a_hs;
  // pipe stage B: oscillator frequency
  logic                        b_valid;
  logic [odrs_pkg::DCO_W-1:0]  b_dco;
  logic [7:0]                  b_n1;
  logic [3:0]                  b_hs;

  // best pair
  logic [odrs_pkg::BEST_W-1:0] best;
  logic [7:0]                  best_n1;
  logic [3:0]                  best_hs;
  logic                        found;
  logic                        b_better;

  // divider
  logic [odrs_pkg::NUM_W-1:0]   num_sr;
  logic [odrs_pkg::XTAL_W:0]    rem;
  logic [odrs_pkg::XTAL_W+1:0]  trial;
  logic [odrs_pkg::XTAL_W:0]    divisor;
  logic                         fits;
  logic [odrs_pkg::RFREQ_W-1:0] quot;
  logic                         ovf;
  logic [5:0]                   div_cnt;
  logic [odrs_pkg::RFREQ_W-1:0] rfreq;

  // output
  logic [3:0] word;
  logic [6:0] n1m1;
  logic [2:0] hsm4;
  logic [7:0] data;

  logic in_fire, out_fire, cfg_write;

  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign cfg_write = psel && penable && pwrite && pready;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == odrs_pkg::CFG_XTAL) ? {5'd0, xtal} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      xtal <= odrs_pkg::XTAL_RESET_HZ;
    end else if (cfg_write && paddr[2] == odrs_pkg::CFG_XTAL) begin
      xtal <= pwdata[odrs_pkg::XTAL_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      odrs_pkg::ST_IDLE: begin
        if (in_fire) state_next = odrs_pkg::ST_SEARCH;
      end
      odrs_pkg::ST_SEARCH: begin
        // leave once every pair is issued and the pipe has drained
        if (issue_done && !a_valid && !b_valid) begin
          state_next = found ? odrs_pkg::ST_DIVIDE : odrs_pkg::ST_EMIT;
        end
      end
      odrs_pkg::ST_DIVIDE: begin
        if (div_cnt == 6'd1) state_next = odrs_pkg::ST_EMIT;
      end
      odrs_pkg::ST_EMIT: begin
        if (out_fire && word == odrs_pkg::WORD_LAST) state_next = odrs_pkg::ST_IDLE;
      end
      default: state_next = odrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= odrs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  assign s_tready = (state == odrs_pkg::ST_IDLE);

  // ---------------- divider search ----------------
  // N1 runs 1, then the even values 2, 4, 6, ..., 128 in the outer loop, HS through its table inside.
  assign n1_cur = (k == 7'd0) ? 8'd1 : {k, 1'b0};
  assign hs_cur = odrs_pkg::hs_of(h);

  // strictly smaller replaces, so the first pair wins on ties
  assign b_better = b_valid
                 && b_dco >= odrs_pkg::DCO_MIN_HZ
                 && b_dco <  odrs_pkg::DCO_MAX_HZ
                 && b_dco <  {8'd0, best};

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_done <= 1'b1;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      found      <= 1'b0;
      k          <= 7'd0;
      h          <= 3'd0;
    end else begin
      if (in_fire) begin
        issue_done <= 1'b0;
        found      <= 1'b0;
        k          <= 7'd0;
        h          <= 3'd0;
        best       <= odrs_pkg::DCO_MAX_HZ[odrs_pkg::BEST_W-1:0];
        target     <= s_tdata[odrs_pkg::TARGET_W-1:0];
      end

      // stage A: issue one pair per cycle
      a_valid <= (state == odrs_pkg::ST_SEARCH) && !issue_done;
      a_nh    <= odrs_pkg::NH_W'(n1_cur) * odrs_pkg::NH_W'(hs_cur);
      a_n1    <= n1_cur;
      a_hs    <= hs_cur;
      if (state == odrs_pkg::ST_SEARCH && !issue_done) begin
        if (h == odrs_pkg::H_LAST) begin
          h <= 3'd0;
          if (k == odrs_pkg::K_LAST) issue_done <= 1'b1;
          else                       k <= k + 7'd1;
        end else begin
          h <= h + 3'd1;
        end
      end

      // stage B: multiply by the target
      b_valid <= a_valid;
      b_dco   <= odrs_pkg::DCO_W'(a_nh) * odrs_pkg::DCO_W'(target);
      b_n1    <= a_n1;
      b_hs    <= a_hs;

      // stage C: compare and keep the best
      if (b_better) begin
        best    <= b_dco[odrs_pkg::BEST_W-1:0];
        best_n1 <= b_n1;
        best_hs <= b_hs;
        found   <= 1'b1;
      end
    end
  end

  // ---------------- RFREQ division ----------------
  // RFREQ = floor((2*dco*2^28 + xtal) / (2*xtal)), one quotient bit a cycle.
  assign divisor = {xtal, 1'b0};
  assign trial   = {rem, num_sr[odrs_pkg::NUM_W-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign rfreq   = ovf ? {odrs_pkg::RFREQ_W{1'b1}} : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 6'd0;
    end else if (state == odrs_pkg::ST_SEARCH) begin
      // hold the numerator ready for the first division step
      num_sr  <= {best, 29'd0} | odrs_pkg::NUM_W'(xtal);
      rem     <= '0;
      quot    <= '0;
      ovf     <= (xtal == '0);
      div_cnt <= odrs_pkg::DIV_STEPS;
    end else if (state == odrs_pkg::ST_DIVIDE) begin
      num_sr  <= {num_sr[odrs_pkg::NUM_W-2:0], 1'b0};
      rem     <= fits ? (odrs_pkg::XTAL_W+1)'(trial - {1'b0, divisor})
                      : trial[odrs_pkg::XTAL_W:0];
      quot    <= {quot[odrs_pkg::RFREQ_W-2:0], fits};
      ovf     <= ovf | quot[odrs_pkg::RFREQ_W-1];
      div_cnt <= div_cnt - 6'd1;
    end
  end

  // ---------------- register writes ----------------
  assign n1m1 = 7'(best_n1 - 8'd1);
  assign hsm4 = 3'(best_hs - 4'd4);

  always_comb begin
    unique case (word)
      4'd0:    data = odrs_pkg::DATA_FREEZE;
      4'd1:    data = found ? {hsm4, n1m1[6:2]} : 8'd0;
      4'd2:    data = found ? {n1m1[1:0], rfreq[37:32]} : 8'd0;
      4'd3:    data = found ? rfreq[31:24] : 8'd0;
      4'd4:    data = found ? rfreq[23:16] : 8'd0;
      4'd5:    data = found ? rfreq[15:8] : 8'd0;
      4'd6:    data = found ? rfreq[7:0] : 8'd0;
      4'd7:    data = odrs_pkg::DATA_THAW;
      default: data = odrs_pkg::DATA_NEWFREQ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= 4'd0;
    end else if (state != odrs_pkg::ST_EMIT) begin
      word <= 4'd0;
    end else if (out_fire) begin
      word <= word + 4'd1;
    end
  end

  assign m_tvalid = (state == odrs_pkg::ST_EMIT);
  assign m_tdata  = {data, odrs_pkg::word_addr(word)};
  assign m_tlast  = (word == odrs_pkg::WORD_LAST);
  assign m_tuser  = !found;

endmodule

// File: design/odrs_checker.sv
// Port-level checks for the oscillator register solver, bound to the top level.
`timescale 1ns / 1ps
`include "oscillator_divider_register_solver_defines.svh"

module odrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  `ODRS_ASSERT_NOW(a_busy_while_emit, m_tvalid, !s_tready, "request taken while writes pending")
  `ODRS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready && !m_tvalid, "block not busy after request")
  `ODRS_ASSERT_NOW(a_last_addr, m_tvalid && m_tlast, m_tdata[7:0] == odrs_pkg::REG_NEWFREQ, "last write is not new-frequency")
  `ODRS_ASSERT_NEXT(a_flag_steady, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser == $past(m_tuser), "no_solution changed within a request")
  `ODRS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled write changed")

endmodule

bind oscillator_divider_register_solver odrs_checker u_odrs_checker (.*);
